// ----- rtl/core/c2s_pkg.sv -----
// Shared constants, types and tables for the Cartesian to spherical converter.
// Holds the rotation angle table, the constant rotation gain and the stage data
// types. Depends on nothing.
package c2s_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int ANGLE_WIDTH     = 16;
    localparam int ROTATION_STAGES = 16;

    localparam int GUARD_BITS  = 16;
    localparam int TABLE_LEN   = 24;
    localparam int STAGE_COUNT = (ROTATION_STAGES > TABLE_LEN) ? TABLE_LEN : ROTATION_STAGES;
    localparam int IDX_W       = $clog2(TABLE_LEN);

    // Angles travel as turns scaled by 2^32
    localparam int TURN_W   = 33;
    localparam int CORDIC_W = COORD_WIDTH + GUARD_BITS + 5;
    localparam int MAG_W    = COORD_WIDTH;
    localparam int RAD_W    = 2 * COORD_WIDTH;
    localparam int ROOT_W   = COORD_WIDTH;
    localparam int REM_W    = ROOT_W + 1;

    localparam int GAIN_W    = 32;
    localparam int GAIN_FRAC = 30;
    localparam int PROD_W    = MAG_W + GAIN_W;
    localparam int ZS_SHIFT  = GAIN_FRAC - GUARD_BITS;
    localparam int ZS_W      = PROD_W - ZS_SHIFT;

    localparam int ANGLE_SHIFT = 32 - ANGLE_WIDTH;

    typedef logic        [IDX_W-1:0]       idx_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [MAG_W-1:0]       mag_t;
    typedef logic        [RAD_W-1:0]       rad_t;
    typedef logic        [ROOT_W-1:0]      root_t;
    typedef logic        [REM_W-1:0]       rem_t;
    typedef logic        [ANGLE_WIDTH-1:0] angle_t;
    typedef logic signed [TURN_W-1:0]      turn_t;
    typedef logic        [TURN_W:0]        turn_u_t;
    typedef logic signed [CORDIC_W-1:0]    cdata_t;
    typedef logic        [GAIN_W-1:0]      gain_t;
    typedef logic        [PROD_W-1:0]      prod_t;
    typedef logic        [ZS_W-1:0]        zs_t;

    localparam turn_u_t QUARTER_TURN = turn_u_t'(64'd1 << 30);
    localparam turn_u_t HALF_TURN    = turn_u_t'(64'd1 << 31);
    localparam turn_u_t FULL_TURN    = turn_u_t'(64'd1 << 32);
    localparam turn_u_t ANGLE_ROUND  = turn_u_t'(64'd1 << (ANGLE_SHIFT - 1));
    localparam prod_t   ZS_ROUND     = prod_t'(64'd1 << (ZS_SHIFT - 1));

    // floor(atan(2^-i) / (2 pi) * 2^32)
    localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [TURN_W-1:0]   ang;
    } cordic_vec_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_vec_t;

    // Elaboration-time integer square root
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rest;
        logic [63:0] res;
        logic [63:0] bit_w;
        rest  = n;
        res   = '0;
        bit_w = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (rest >= res + bit_w)
            begin
                rest = rest - (res + bit_w);
                res  = (res >> 1) + bit_w;
            end
            else
            begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // Product of the stage gains squared, truncated in Q30, then square-rooted
    function automatic logic [63:0] calc_gain_q30();
        logic [63:0] p;
        p = 64'd1 << 30;
        for (int i = 0; i < STAGE_COUNT; i++)
        begin
            p = p + (p >> (2 * i));
        end
        return isqrt64(p << 30);
    endfunction

    localparam gain_t GAIN_Q30 = gain_t'(calc_gain_q30());

endpackage

// ----- rtl/core/c2s_point_if.sv -----
// Input channel carrying one Cartesian point per transaction.
// Depends on c2s_pkg.
interface c2s_point_if;
    logic                  valid;
    logic                  ready;
    c2s_pkg::coord_t       coord_x;
    c2s_pkg::coord_t       coord_y;
    c2s_pkg::coord_t       coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

// ----- rtl/core/c2s_result_if.sv -----
// Output channel carrying one set of spherical coordinates per transaction.
// Depends on c2s_pkg.
interface c2s_result_if;
    logic                  valid;
    logic                  ready;
    c2s_pkg::root_t        radius;
    c2s_pkg::root_t        planar_radius;
    c2s_pkg::angle_t       inclination;
    c2s_pkg::angle_t       azimuth;

    modport source (output valid, output radius, output planar_radius,
                    output inclination, output azimuth, input ready);
    modport sink   (input valid, input radius, input planar_radius,
                    input inclination, input azimuth, output ready);
endinterface

// ----- rtl/core/c2s_cordic_cell.sv -----
// One vectoring rotation cell: a shift-add micro-rotation plus angle update,
// registered. Depends on c2s_pkg.
module c2s_cordic_cell (
    input  logic                  clk,
    input  logic                  en,
    input  c2s_pkg::idx_t         idx,
    input  c2s_pkg::cordic_vec_t  vec_in,
    output c2s_pkg::cordic_vec_t  vec_out
);

    c2s_pkg::cdata_t      x_in;
    c2s_pkg::cdata_t      y_in;
    c2s_pkg::cdata_t      dx;
    c2s_pkg::cdata_t      dy;
    c2s_pkg::turn_t       step;
    c2s_pkg::cordic_vec_t vec_reg;
    c2s_pkg::cordic_vec_t vec_next;

    always_comb
    begin
        x_in = vec_in.x;
        y_in = vec_in.y;
        dx   = y_in >>> idx;
        dy   = x_in >>> idx;
        step = c2s_pkg::turn_t'(c2s_pkg::ATAN_TURNS[idx]);
        // rotate towards the x axis; a zero y counts as above it
        if (!y_in[c2s_pkg::CORDIC_W-1])
        begin
            vec_next.x   = x_in + dx;
            vec_next.y   = y_in - dy;
            vec_next.ang = vec_in.ang + step;
        end
        else
        begin
            vec_next.x   = x_in - dx;
            vec_next.y   = y_in + dy;
            vec_next.ang = vec_in.ang - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

// ----- rtl/core/c2s_sqrt_cell.sv -----
// One digit of a restoring integer square root: takes two radicand bits,
// yields one root bit and the running remainder, registered. Depends on c2s_pkg.
module c2s_sqrt_cell (
    input  logic                clk,
    input  logic                en,
    input  c2s_pkg::sqrt_vec_t  vec_in,
    output c2s_pkg::sqrt_vec_t  vec_out
);

    logic [c2s_pkg::REM_W+1:0] cur;
    logic [c2s_pkg::REM_W+1:0] trial;
    c2s_pkg::sqrt_vec_t        vec_reg;
    c2s_pkg::sqrt_vec_t        vec_next;

    always_comb
    begin
        cur          = {vec_in.rem, vec_in.rad[c2s_pkg::RAD_W-1 -: 2]};
        trial        = {1'b0, vec_in.root, 2'b01};
        vec_next.rad = {vec_in.rad[c2s_pkg::RAD_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            vec_next.rem  = c2s_pkg::rem_t'(cur - trial);
            vec_next.root = {vec_in.root[c2s_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            vec_next.rem  = c2s_pkg::rem_t'(cur);
            vec_next.root = {vec_in.root[c2s_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

// ----- rtl/core/cartesian_to_spherical.sv -----
// Cartesian to spherical converter: radius, planar radius, inclination, azimuth.
// The two rotation chains (16 cells each) run in series, followed by the angle
// fold and output registers. Throughput: one point per cycle, sustained while
// the skid stage is empty.
// Reset clears every valid bit, including those of the output and skid stages.
// Depends on c2s_pkg, c2s_point_if, c2s_result_if, c2s_cordic_cell, c2s_sqrt_cell.
module cartesian_to_spherical (
    input  logic          clk,
    input  logic          rst_n,
    c2s_point_if.sink     point,
    c2s_result_if.source  result
);

    localparam int STAGES    = c2s_pkg::STAGE_COUNT;
    localparam int ROOT_W    = c2s_pkg::ROOT_W;
    localparam int SQRT_END  = ROOT_W + 2;
    localparam int LAST      = ((2 * STAGES > SQRT_END) ? 2 * STAGES : SQRT_END) + 1;
    localparam int AZ_DEPTH  = LAST - STAGES;
    localparam int INC_DEPTH = LAST - 2 * STAGES;
    localparam int RAD_DEPTH = LAST - SQRT_END;
    localparam int ZS_DEPTH  = STAGES - 1;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic zero_x;
        logic zero_y;
        logic zero_z;
    } flags_t;

    typedef struct packed {
        c2s_pkg::root_t  radius;
        c2s_pkg::root_t  planar_radius;
        c2s_pkg::angle_t inclination;
        c2s_pkg::angle_t azimuth;
    } out_item_t;

    function automatic c2s_pkg::turn_u_t clamp_turns(input c2s_pkg::turn_t ang);
        c2s_pkg::turn_u_t u;
        u = c2s_pkg::turn_u_t'(ang);
        if (ang[c2s_pkg::TURN_W-1])
        begin
            u = '0;
        end
        else if (u > c2s_pkg::QUARTER_TURN)
        begin
            u = c2s_pkg::QUARTER_TURN;
        end
        return u;
    endfunction

    function automatic c2s_pkg::angle_t to_angle(input c2s_pkg::turn_u_t t);
        c2s_pkg::turn_u_t r;
        r = t + c2s_pkg::ANGLE_ROUND;
        return c2s_pkg::angle_t'(r >> c2s_pkg::ANGLE_SHIFT);
    endfunction

    function automatic c2s_pkg::root_t round_root(input c2s_pkg::sqrt_vec_t v);
        c2s_pkg::rem_t s;
        c2s_pkg::root_t r;
        s = c2s_pkg::rem_t'(v.root);
        if (v.rem > s)
        begin
            s = s + c2s_pkg::rem_t'(1);
        end
        // saturate at the field maximum
        if (s[ROOT_W])
        begin
            r = '1;
        end
        else
        begin
            r = c2s_pkg::root_t'(s);
        end
        return r;
    endfunction

    logic                 adv;
    logic [LAST:0]        valid_reg;
    logic [LAST:0]        valid_next;

    c2s_pkg::mag_t        mag_x_reg;
    c2s_pkg::mag_t        mag_y_reg;
    c2s_pkg::mag_t        mag_z_reg;
    c2s_pkg::mag_t        mag_x_next;
    c2s_pkg::mag_t        mag_y_next;
    c2s_pkg::mag_t        mag_z_next;
    flags_t               flags_next;
    flags_t               flags_reg [2*STAGES+1];

    c2s_pkg::rad_t        sq_x_reg;
    c2s_pkg::rad_t        sq_y_reg;
    c2s_pkg::rad_t        sq_z_reg;
    c2s_pkg::prod_t       prod_reg;
    c2s_pkg::rad_t        sum_xy_reg;
    c2s_pkg::rad_t        sum_xyz_reg;
    c2s_pkg::zs_t         zs_reg [ZS_DEPTH];

    c2s_pkg::cordic_vec_t az_vec   [STAGES+1];
    c2s_pkg::cordic_vec_t incl_vec [STAGES+1];
    c2s_pkg::sqrt_vec_t   rp_vec   [ROOT_W+1];
    c2s_pkg::sqrt_vec_t   r3_vec   [ROOT_W+1];

    c2s_pkg::angle_t      azim_next;
    c2s_pkg::angle_t      incl_next;
    c2s_pkg::angle_t      azim_reg   [AZ_DEPTH];
    c2s_pkg::angle_t      incl_reg   [INC_DEPTH];
    c2s_pkg::root_t       radius_reg [RAD_DEPTH];
    c2s_pkg::root_t       planar_reg [RAD_DEPTH];

    c2s_pkg::turn_u_t     az_t;
    c2s_pkg::turn_u_t     az_turns;
    c2s_pkg::turn_u_t     inc_t;
    c2s_pkg::turn_u_t     inc_turns;
    flags_t               az_flags;
    flags_t               inc_flags;

    out_item_t            pipe_item;
    out_item_t            out_reg;
    out_item_t            out_next;
    out_item_t            skid_reg;
    out_item_t            skid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic                 out_fire;

    // Whole pipeline holds only while the skid stage is occupied
    assign adv         = !skid_valid_reg;
    assign point.ready = adv;

    always_comb
    begin
        valid_next = valid_reg;
        if (adv)
        begin
            valid_next = {valid_reg[LAST-1:0], point.valid};
        end
    end

    // Rank 0: magnitudes and sign/zero flags
    always_comb
    begin
        mag_x_next        = c2s_pkg::mag_t'(point.coord_x[c2s_pkg::COORD_WIDTH-1] ?
                                            -point.coord_x : point.coord_x);
        mag_y_next        = c2s_pkg::mag_t'(point.coord_y[c2s_pkg::COORD_WIDTH-1] ?
                                            -point.coord_y : point.coord_y);
        mag_z_next        = c2s_pkg::mag_t'(point.coord_z[c2s_pkg::COORD_WIDTH-1] ?
                                            -point.coord_z : point.coord_z);
        flags_next.neg_x  = point.coord_x[c2s_pkg::COORD_WIDTH-1];
        flags_next.neg_y  = point.coord_y[c2s_pkg::COORD_WIDTH-1];
        flags_next.neg_z  = point.coord_z[c2s_pkg::COORD_WIDTH-1];
        flags_next.zero_x = (point.coord_x == '0);
        flags_next.zero_y = (point.coord_y == '0);
        flags_next.zero_z = (point.coord_z == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_x_reg    <= mag_x_next;
            mag_y_reg    <= mag_y_next;
            mag_z_reg    <= mag_z_next;
            flags_reg[0] <= flags_next;
            for (int k = 1; k < 2 * STAGES + 1; k++)
            begin
                flags_reg[k] <= flags_reg[k-1];
            end
            sq_x_reg    <= c2s_pkg::rad_t'(mag_x_reg) * c2s_pkg::rad_t'(mag_x_reg);
            sq_y_reg    <= c2s_pkg::rad_t'(mag_y_reg) * c2s_pkg::rad_t'(mag_y_reg);
            sq_z_reg    <= c2s_pkg::rad_t'(mag_z_reg) * c2s_pkg::rad_t'(mag_z_reg);
            prod_reg    <= c2s_pkg::prod_t'(mag_z_reg) * c2s_pkg::prod_t'(c2s_pkg::GAIN_Q30);
            sum_xy_reg  <= sq_x_reg + sq_y_reg;
            sum_xyz_reg <= sq_x_reg + sq_y_reg + sq_z_reg;
            // scale |z| by the chain gain so both legs of the second rotation match
            zs_reg[0]   <= c2s_pkg::zs_t'((prod_reg + c2s_pkg::ZS_ROUND) >> c2s_pkg::ZS_SHIFT);
            for (int k = 1; k < ZS_DEPTH; k++)
            begin
                zs_reg[k] <= zs_reg[k-1];
            end
        end
    end

    // Azimuth rotation chain
    assign az_vec[0].x   = c2s_pkg::cdata_t'({mag_x_reg, {c2s_pkg::GUARD_BITS{1'b0}}});
    assign az_vec[0].y   = c2s_pkg::cdata_t'({mag_y_reg, {c2s_pkg::GUARD_BITS{1'b0}}});
    assign az_vec[0].ang = '0;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_az
        c2s_cordic_cell u_cell (
            .clk     (clk),
            .en      (adv),
            .idx     (c2s_pkg::idx_t'(i)),
            .vec_in  (az_vec[i]),
            .vec_out (az_vec[i+1])
        );
    end

    // Inclination rotation chain: (scaled |z|, planar result of the azimuth chain)
    assign incl_vec[0].x   = c2s_pkg::cdata_t'(zs_reg[ZS_DEPTH-1]);
    assign incl_vec[0].y   = az_vec[STAGES].x;
    assign incl_vec[0].ang = '0;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_incl
        c2s_cordic_cell u_cell (
            .clk     (clk),
            .en      (adv),
            .idx     (c2s_pkg::idx_t'(i)),
            .vec_in  (incl_vec[i]),
            .vec_out (incl_vec[i+1])
        );
    end

    // Square root chains for both radii
    assign rp_vec[0].rad  = sum_xy_reg;
    assign rp_vec[0].rem  = '0;
    assign rp_vec[0].root = '0;
    assign r3_vec[0].rad  = sum_xyz_reg;
    assign r3_vec[0].rem  = '0;
    assign r3_vec[0].root = '0;

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        c2s_sqrt_cell u_planar (
            .clk     (clk),
            .en      (adv),
            .vec_in  (rp_vec[j]),
            .vec_out (rp_vec[j+1])
        );
        c2s_sqrt_cell u_full (
            .clk     (clk),
            .en      (adv),
            .vec_in  (r3_vec[j]),
            .vec_out (r3_vec[j+1])
        );
    end

    // Azimuth: fold the first-quadrant angle back into its quadrant
    always_comb
    begin
        az_flags = flags_reg[STAGES];
        priority if (az_flags.zero_y)
        begin
            az_t = '0;
        end
        else if (az_flags.zero_x)
        begin
            az_t = c2s_pkg::QUARTER_TURN;
        end
        else
        begin
            az_t = clamp_turns(az_vec[STAGES].ang);
        end
        priority if (!az_flags.neg_x && !az_flags.neg_y)
        begin
            az_turns = az_t;
        end
        else if (az_flags.neg_x && !az_flags.neg_y)
        begin
            az_turns = c2s_pkg::HALF_TURN - az_t;
        end
        else if (az_flags.neg_x)
        begin
            az_turns = c2s_pkg::HALF_TURN + az_t;
        end
        else
        begin
            az_turns = c2s_pkg::FULL_TURN - az_t;
        end
        azim_next = (az_flags.zero_x && az_flags.zero_y) ? '0 : to_angle(az_turns);
    end

    // Inclination: mirror about pi/2 for negative z
    always_comb
    begin
        inc_flags = flags_reg[2*STAGES];
        priority if (inc_flags.zero_x && inc_flags.zero_y)
        begin
            inc_t = '0;
        end
        else if (inc_flags.zero_z)
        begin
            inc_t = c2s_pkg::QUARTER_TURN;
        end
        else
        begin
            inc_t = clamp_turns(incl_vec[STAGES].ang);
        end
        inc_turns = inc_flags.neg_z ? (c2s_pkg::HALF_TURN - inc_t) : inc_t;
        incl_next = (inc_flags.zero_x && inc_flags.zero_y && inc_flags.zero_z) ?
                    '0 : to_angle(inc_turns);
    end

    // Align every result to the last rank
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            azim_reg[0]   <= azim_next;
            incl_reg[0]   <= incl_next;
            radius_reg[0] <= round_root(r3_vec[ROOT_W]);
            planar_reg[0] <= round_root(rp_vec[ROOT_W]);
            for (int k = 1; k < AZ_DEPTH; k++)
            begin
                azim_reg[k] <= azim_reg[k-1];
            end
            for (int k = 1; k < INC_DEPTH; k++)
            begin
                incl_reg[k] <= incl_reg[k-1];
            end
            for (int k = 1; k < RAD_DEPTH; k++)
            begin
                radius_reg[k] <= radius_reg[k-1];
                planar_reg[k] <= planar_reg[k-1];
            end
        end
    end

    always_comb
    begin
        pipe_item.radius        = radius_reg[RAD_DEPTH-1];
        pipe_item.planar_radius = planar_reg[RAD_DEPTH-1];
        pipe_item.inclination   = incl_reg[INC_DEPTH-1];
        pipe_item.azimuth       = azim_reg[AZ_DEPTH-1];
    end

    // Output register with a skid stage behind it
    always_comb
    begin
        out_fire        = out_valid_reg && result.ready;
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        priority if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_next       = pipe_item;
            out_valid_next = valid_reg[LAST];
        end
        else
        begin
            // park the transaction while the output is stalled
            skid_next       = pipe_item;
            skid_valid_next = valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.radius        = out_reg.radius;
    assign result.planar_radius = out_reg.planar_radius;
    assign result.inclination   = out_reg.inclination;
    assign result.azimuth       = out_reg.azimuth;

endmodule
